/* src/object_handle_hash_lookup_assert.svh */
// Assertion macros for the handle lookup block.
// Each macro takes a label, the clock, the reset, the checked expression and a message.
`ifndef OBJECT_HANDLE_HASH_LOOKUP_ASSERT_SVH
`define OBJECT_HANDLE_HASH_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define OHHL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OHHL_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define OHHL_ASSERT(label, clk, rst, prop, msg)
`define OHHL_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

/* src/ohhl_pkg.sv */
package ohhl_pkg;

   // Instance memory geometry
   localparam int MEM_WORDS      = 65536;
   localparam int MEM_IDX_W      = $clog2(MEM_WORDS);
   localparam int PROBE_CHANNELS = 32;

   // Widths of internal paths
   localparam int RA_W       = 18;   // word address of any read, incl. type word
   localparam int SCAN_W     = 13;   // word index inside the largest table
   localparam int HASH_W     = 15;   // folded hash shifted to an 8-byte entry
   localparam int CHAN_W     = 5;
   localparam int OFF_W      = 16;
   localparam int PAGE_W     = 5;
   localparam int SIZE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam int HASH_BASE_BITS  = 9;
   localparam int TABLE_WORDS_MIN = 1024;   // 4 KB table
   localparam int PAGE_WORD_SHIFT = 10;     // 4 KB page in words

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_CODE = 2'd1;

   // Item functions
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Search methods
   localparam logic [1:0] METH_NONE  = 2'd0;
   localparam logic [1:0] METH_PROBE = 2'd1;
   localparam logic [1:0] METH_SCAN  = 2'd2;

   // Context engine field that selects the instance type byte
   localparam logic [1:0] ENGINE_INST = 2'd1;

   typedef struct packed {
      logic clr_wr;
      logic wr;
      logic start;
      logic search_step;
      logic hit_take;
      logic miss_take;
      logic ctx_take;
      logic type_take;
      logic out_load;
   } ohhl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic hit;
      logic miss;
      logic eng_inst;
   } ohhl_sts_type;

endpackage

/* src/object_handle_hash_lookup.sv */
// Handle lookup in a xor-folded hash table held in a 64K-word instance memory.
// Request channel (req_): func 0 writes req_write_data at req_word_address and
// gives no result; func 1 looks up req_handle and gives one result on the
// response channel (rsp_). Both channels transfer when valid is high and
// stall is low. The csr_ port sets the table base page and size code; write
// it only while the block is idle.
// A lookup walks the probe channels and then, if no probe matches, every
// word of the table, issuing one read per cycle through the single memory
// read port. On a hit it reads the context word that follows the entry; the
// type byte comes from that context's instance word when its engine field
// selects one, and from bits 15:8 of the handle otherwise.
// After reset a clearing pass zeroes the memory one word per cycle, with
// req_stall high until it ends. The result sits in an output register: the
// block takes the next item while it waits, and holds a newer result until
// the stalled one has transferred.
`include "object_handle_hash_lookup_assert.svh"

module object_handle_hash_lookup (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic [15:0]                      req_word_address,
   input  logic [31:0]                      req_write_data,
   input  logic [31:0]                      req_handle,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic [7:0]                       rsp_object_type,
   output logic [15:0]                      rsp_entry_offset,
   output logic [1:0]                       rsp_search_method,
   output logic [4:0]                       rsp_channel,
   input  logic                             csr_we,
   input  logic [ohhl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ohhl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ohhl_pkg::ohhl_cmd_type cmd;
   ohhl_pkg::ohhl_sts_type sts;

   ohhl_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ohhl_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_word_address  (req_word_address),
      .req_write_data    (req_write_data),
      .req_handle        (req_handle),
      .rsp_found         (rsp_found),
      .rsp_object_type   (rsp_object_type),
      .rsp_entry_offset  (rsp_entry_offset),
      .rsp_search_method (rsp_search_method),
      .rsp_channel       (rsp_channel)
   );

   // Terms for the checks below
   logic rsp_held;
   logic lookup_take;
   logic miss_fields_zero;
   logic chan_stray;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign lookup_take = req_valid && !req_stall && (req_func == ohhl_pkg::FUNC_LOOKUP);
   assign miss_fields_zero = (rsp_search_method == ohhl_pkg::METH_NONE) &&
                             (rsp_entry_offset == 16'd0) && (rsp_channel == 5'd0) &&
                             (rsp_object_type == 8'd0);
   assign chan_stray  = rsp_valid && (rsp_search_method != ohhl_pkg::METH_PROBE) &&
                        (rsp_channel != 5'd0);

   // A new result never replaces one that is still stalled
   `OHHL_ASSERT(a_out_free, clock, reset, cmd.out_load |-> !rsp_held, "result overwritten")
   // An accepted lookup keeps the request side busy in the next cycle
   `OHHL_ASSERT(a_lookup_busy, clock, reset, lookup_take |=> req_stall, "lookup not blocking")
   // A miss carries no method, offset, channel or type
   `OHHL_ASSERT(a_miss_clean, clock, reset, (rsp_valid && !rsp_found) |-> miss_fields_zero, "miss not cleared")
   // Only a probe hit reports a channel
   `OHHL_ASSERT_NEVER(a_chan_probe, clock, reset, chan_stray, "channel set outside a probe hit")

endmodule

/* src/ohhl_datapath.sv */
module ohhl_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ohhl_pkg::ohhl_cmd_type                cmd,
   output ohhl_pkg::ohhl_sts_type                sts,
   input  logic                                  csr_we,
   input  logic [ohhl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ohhl_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [15:0]                           req_word_address,
   input  logic [31:0]                           req_write_data,
   input  logic [31:0]                           req_handle,
   output logic                                  rsp_found,
   output logic [7:0]                            rsp_object_type,
   output logic [15:0]                           rsp_entry_offset,
   output logic [1:0]                            rsp_search_method,
   output logic [4:0]                            rsp_channel
);

   // Xor-fold the handle into 9 + code bits, then scale to an 8-byte entry
   function automatic logic [ohhl_pkg::HASH_W-1:0] fold_hash(input logic [31:0] h,
                                                             input logic [1:0]  code);
      logic [11:0] f;
      unique case (code)
         2'd0: f = 12'(h[8:0])  ^ 12'(h[17:9])  ^ 12'(h[26:18]) ^ 12'(h[31:27]);
         2'd1: f = 12'(h[9:0])  ^ 12'(h[19:10]) ^ 12'(h[29:20]) ^ 12'(h[31:30]);
         2'd2: f = 12'(h[10:0]) ^ 12'(h[21:11]) ^ 12'(h[31:22]);
         2'd3: f = h[11:0]      ^ h[23:12]      ^ 12'(h[31:24]);
         default: f = '0;
      endcase
      return {f, 3'b000};
   endfunction

   // Configuration
   logic [ohhl_pkg::PAGE_W-1:0] base_page_ff, base_page_in;
   logic [ohhl_pkg::SIZE_W-1:0] size_code_ff, size_code_in;

   // Instance memory and its read port
   logic [31:0]                    mem [ohhl_pkg::MEM_WORDS];
   logic [31:0]                    rdata_ff;
   logic                           oor_ff;
   logic                           rd_en;
   logic [ohhl_pkg::RA_W-1:0]      rd_addr;
   logic                           rd_ok;
   logic                           wr_en;
   logic [ohhl_pkg::MEM_IDX_W-1:0] wr_idx;
   logic [31:0]                    wr_data;
   logic [31:0]                    rd_word;

   // Clearing pass
   logic [ohhl_pkg::MEM_IDX_W-1:0] clr_ff, clr_in;

   // Lookup state
   logic [31:0]                    handle_ff, handle_in;
   logic [ohhl_pkg::HASH_W-1:0]    hash_ff, hash_in;
   logic                           iss_scan_ff, iss_scan_in;
   logic [ohhl_pkg::SCAN_W-1:0]    iss_idx_ff, iss_idx_in;
   logic                           iss_done_ff, iss_done_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic                           pend_scan_ff, pend_scan_in;
   logic [ohhl_pkg::OFF_W-1:0]     pend_off_ff, pend_off_in;
   logic [ohhl_pkg::RA_W-1:0]      pend_word_ff, pend_word_in;
   logic [ohhl_pkg::CHAN_W-1:0]    pend_chan_ff, pend_chan_in;

   // Result being built and output register
   logic                           res_found_ff, res_found_in;
   logic [7:0]                     res_type_ff, res_type_in;
   logic [ohhl_pkg::OFF_W-1:0]     res_off_ff, res_off_in;
   logic [1:0]                     res_method_ff, res_method_in;
   logic [ohhl_pkg::CHAN_W-1:0]    res_chan_ff, res_chan_in;
   logic                           out_found_ff, out_found_in;
   logic [7:0]                     out_type_ff, out_type_in;
   logic [ohhl_pkg::OFF_W-1:0]     out_off_ff, out_off_in;
   logic [1:0]                     out_method_ff, out_method_in;
   logic [ohhl_pkg::CHAN_W-1:0]    out_chan_ff, out_chan_in;

   // Address arithmetic
   logic [ohhl_pkg::RA_W-1:0]      base_word;
   logic [ohhl_pkg::CHAN_W-1:0]    cur_chan;
   logic [3:0]                     salt_shift;
   logic [ohhl_pkg::OFF_W-1:0]     probe_off;
   logic [ohhl_pkg::OFF_W-1:0]     scan_off;
   logic [ohhl_pkg::OFF_W-1:0]     cur_off;
   logic [ohhl_pkg::RA_W-1:0]      cur_word;
   logic [ohhl_pkg::SCAN_W:0]      scan_words;
   logic [ohhl_pkg::SCAN_W-1:0]    scan_last;
   logic                           probe_last;
   logic                           eng_inst;

   // Form the address of the current probe or scan word
   always_comb begin
      base_word  = ohhl_pkg::RA_W'(base_page_ff) << ohhl_pkg::PAGE_WORD_SHIFT;
      cur_chan   = iss_idx_ff[ohhl_pkg::CHAN_W-1:0];
      salt_shift = 4'(ohhl_pkg::HASH_BASE_BITS - 1) + 4'(size_code_ff);
      probe_off  = ohhl_pkg::OFF_W'(hash_ff) ^ (ohhl_pkg::OFF_W'(cur_chan) << salt_shift);
      scan_off   = ohhl_pkg::OFF_W'({iss_idx_ff, 2'b00});
      cur_off    = iss_scan_ff ? scan_off : probe_off;
      cur_word   = base_word + ohhl_pkg::RA_W'(cur_off[ohhl_pkg::OFF_W-1:2]);
      scan_words = (ohhl_pkg::SCAN_W+1)'(ohhl_pkg::TABLE_WORDS_MIN) << size_code_ff;
      scan_last  = ohhl_pkg::SCAN_W'(scan_words - 1'b1);
      probe_last = (iss_idx_ff == ohhl_pkg::SCAN_W'(ohhl_pkg::PROBE_CHANNELS - 1));
   end

   // Out-of-range words read as zero
   assign rd_word  = oor_ff ? 32'd0 : rdata_ff;
   assign eng_inst = (rd_word[17:16] == ohhl_pkg::ENGINE_INST);

   // Status to the controller
   always_comb begin
      sts.clr_last = (clr_ff == ohhl_pkg::MEM_IDX_W'(ohhl_pkg::MEM_WORDS - 1));
      sts.hit      = pend_valid_ff && (rd_word == handle_ff);
      sts.miss     = iss_done_ff && !pend_valid_ff;
      sts.eng_inst = eng_inst;
   end

   // Select the read address
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.search_step && !iss_done_ff) begin
         rd_en   = 1'b1;
         rd_addr = cur_word;
      end else if (cmd.hit_take) begin
         rd_en   = 1'b1;
         rd_addr = pend_word_ff + 1'b1;
      end else if (cmd.ctx_take && eng_inst) begin
         rd_en   = 1'b1;
         rd_addr = ohhl_pkg::RA_W'({rd_word[15:0], 2'b00});
      end
      rd_ok = 32'(rd_addr) < ohhl_pkg::MEM_WORDS;
   end

   // Select the write: clearing pass or write item
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = clr_ff;
      wr_data = '0;
      if (cmd.clr_wr) begin
         wr_en = 1'b1;
      end else if (cmd.wr && (32'(req_word_address) < ohhl_pkg::MEM_WORDS)) begin
         wr_en   = 1'b1;
         wr_idx  = ohhl_pkg::MEM_IDX_W'(req_word_address);
         wr_data = req_write_data;
      end
   end

   // Memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Memory read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[ohhl_pkg::MEM_IDX_W'(rd_addr)];
         oor_ff   <= !rd_ok;
      end
   end

   // Configuration writes
   always_comb begin
      base_page_in = base_page_ff;
      size_code_in = size_code_ff;
      if (csr_we) begin
         unique case (csr_index)
            ohhl_pkg::CSR_BASE_PAGE: base_page_in = csr_wdata[ohhl_pkg::PAGE_W-1:0];
            ohhl_pkg::CSR_SIZE_CODE: size_code_in = csr_wdata[ohhl_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the clearing counter
   assign clr_in = cmd.clr_wr ? clr_ff + 1'b1 : clr_ff;

   // Issue probes, then scan words, and track the read in flight
   always_comb begin
      handle_in     = handle_ff;
      hash_in       = hash_ff;
      iss_scan_in   = iss_scan_ff;
      iss_idx_in    = iss_idx_ff;
      iss_done_in   = iss_done_ff;
      pend_valid_in = pend_valid_ff;
      pend_scan_in  = pend_scan_ff;
      pend_off_in   = pend_off_ff;
      pend_word_in  = pend_word_ff;
      pend_chan_in  = pend_chan_ff;
      if (cmd.start) begin
         handle_in     = req_handle;
         hash_in       = fold_hash(req_handle, size_code_ff);
         iss_scan_in   = 1'b0;
         iss_idx_in    = '0;
         iss_done_in   = 1'b0;
         pend_valid_in = 1'b0;
      end else if (cmd.search_step) begin
         if (iss_done_ff) begin
            pend_valid_in = 1'b0;
         end else begin
            pend_valid_in = 1'b1;
            pend_scan_in  = iss_scan_ff;
            pend_off_in   = cur_off;
            pend_word_in  = cur_word;
            pend_chan_in  = iss_scan_ff ? '0 : cur_chan;
            if (!iss_scan_ff && probe_last) begin
               iss_scan_in = 1'b1;
               iss_idx_in  = '0;
            end else if (iss_scan_ff && (iss_idx_ff == scan_last)) begin
               iss_done_in = 1'b1;
            end else begin
               iss_idx_in = iss_idx_ff + 1'b1;
            end
         end
      end
   end

   // Build the result and load the output register
   always_comb begin
      res_found_in  = res_found_ff;
      res_type_in   = res_type_ff;
      res_off_in    = res_off_ff;
      res_method_in = res_method_ff;
      res_chan_in   = res_chan_ff;
      out_found_in  = out_found_ff;
      out_type_in   = out_type_ff;
      out_off_in    = out_off_ff;
      out_method_in = out_method_ff;
      out_chan_in   = out_chan_ff;
      if (cmd.hit_take) begin
         res_found_in  = 1'b1;
         res_off_in    = pend_off_ff;
         res_method_in = pend_scan_ff ? ohhl_pkg::METH_SCAN : ohhl_pkg::METH_PROBE;
         res_chan_in   = pend_chan_ff;
      end
      if (cmd.miss_take) begin
         res_found_in  = 1'b0;
         res_type_in   = '0;
         res_off_in    = '0;
         res_method_in = ohhl_pkg::METH_NONE;
         res_chan_in   = '0;
      end
      if (cmd.ctx_take && !eng_inst) begin
         res_type_in = handle_ff[15:8];
      end
      if (cmd.type_take) begin
         res_type_in = rd_word[7:0];
      end
      if (cmd.out_load) begin
         out_found_in  = res_found_ff;
         out_type_in   = res_type_ff;
         out_off_in    = res_off_ff;
         out_method_in = res_method_ff;
         out_chan_in   = res_chan_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_page_ff  <= '0;
         size_code_ff  <= '0;
         clr_ff        <= '0;
         iss_scan_ff   <= 1'b0;
         iss_idx_ff    <= '0;
         iss_done_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         base_page_ff  <= base_page_in;
         size_code_ff  <= size_code_in;
         clr_ff        <= clr_in;
         iss_scan_ff   <= iss_scan_in;
         iss_idx_ff    <= iss_idx_in;
         iss_done_ff   <= iss_done_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      handle_ff     <= handle_in;
      hash_ff       <= hash_in;
      pend_scan_ff  <= pend_scan_in;
      pend_off_ff   <= pend_off_in;
      pend_word_ff  <= pend_word_in;
      pend_chan_ff  <= pend_chan_in;
      res_found_ff  <= res_found_in;
      res_type_ff   <= res_type_in;
      res_off_ff    <= res_off_in;
      res_method_ff <= res_method_in;
      res_chan_ff   <= res_chan_in;
      out_found_ff  <= out_found_in;
      out_type_ff   <= out_type_in;
      out_off_ff    <= out_off_in;
      out_method_ff <= out_method_in;
      out_chan_ff   <= out_chan_in;
   end

   assign rsp_found         = out_found_ff;
   assign rsp_object_type   = out_type_ff;
   assign rsp_entry_offset  = out_off_ff;
   assign rsp_search_method = out_method_ff;
   assign rsp_channel       = out_chan_ff;

endmodule

/* src/ohhl_controller.sv */
module ohhl_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ohhl_pkg::ohhl_cmd_type cmd,
   input  ohhl_pkg::ohhl_sts_type sts
);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SEARCH = 6'b000100,
      S_CTX    = 6'b001000,
      S_TYPE   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Run the clearing pass, then sequence each lookup through search, context and type reads
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == ohhl_pkg::FUNC_LOOKUP) begin
                  cmd.start = 1'b1;
                  state_in  = S_SEARCH;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         S_SEARCH: begin
            if (sts.hit) begin
               cmd.hit_take = 1'b1;
               state_in     = S_CTX;
            end else if (sts.miss) begin
               cmd.miss_take = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_CTX: begin
            cmd.ctx_take = 1'b1;
            state_in     = sts.eng_inst ? S_TYPE : S_DONE;
         end
         S_TYPE: begin
            cmd.type_take = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
